>>> rtl/lwc_pkg.sv
`default_nettype none

package lwc_pkg;

    // Field widths of the stream words
    localparam int FEAT_W   = 16;
    localparam int COORD_W  = 5;
    localparam int SCORE_W  = 37;
    localparam int OFFSET_W = 6;
    localparam int PROD_W   = 2 * FEAT_W;

    // Register field widths
    localparam int ROI_W  = 4;
    localparam int DIM_W  = 6;
    localparam int WIN_W  = 3;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_ROI_SIZE      = 2'd0;
    localparam logic [1:0] REG_MAP_HEIGHT    = 2'd1;
    localparam logic [1:0] REG_MAP_WIDTH     = 2'd2;
    localparam logic [1:0] REG_CHANNEL_COUNT = 2'd3;

    // Register reset values
    localparam logic [ROI_W-1:0] ROI_SIZE_RST      = 4'd3;
    localparam logic [DIM_W-1:0] MAP_HEIGHT_RST    = 6'd32;
    localparam logic [DIM_W-1:0] MAP_WIDTH_RST     = 6'd32;
    localparam logic [DIM_W-1:0] CHANNEL_COUNT_RST = 6'd32;

    // Word kinds and load targets
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;
    localparam logic MAP_IMAGE  = 1'b0;
    localparam logic MAP_KERNEL = 1'b1;

    // Score saturation bounds
    localparam longint SCORE_MAX = 64'sd68719476735;
    localparam longint SCORE_MIN = -64'sd68719476736;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } lwc_state_t;

    // Effective (clamped) configuration
    typedef struct packed {
        logic [ROI_W-1:0] roi;
        logic [DIM_W-1:0] height;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] chans;
    } lwc_cfg_t;

    // Controller to datapath
    typedef struct packed {
        logic                load_wr;
        logic                query_cap;
        logic                issue;
        logic                first;
        logic                last_chan;
        logic                last_pos;
        logic [WIN_W-1:0]    dy;
        logic [WIN_W-1:0]    dx;
        logic [DIM_W-1:0]    chan;
        logic [OFFSET_W-1:0] offset;
    } lwc_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic advance;
        logic pos_inside;
    } lwc_status_t;

    // Clamp a register into 1..hi
    function automatic logic [DIM_W-1:0] clamp_cfg(input logic [DIM_W-1:0] v, input int hi);
        logic [DIM_W-1:0] r;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (int'(v) > hi)
        begin
            r = DIM_W'(hi);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/lwc_ctrl.sv
`default_nettype none

module lwc_ctrl
    import lwc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire lwc_cfg_t    cfg,
    input  wire logic        in_valid,
    input  wire logic        in_func,
    input  wire lwc_status_t status,
    output logic             in_ready,
    output lwc_cmd_t         cmd
);

    lwc_state_t          state_reg, state_next;
    logic [WIN_W-1:0]    dy_reg, dy_next;
    logic [WIN_W-1:0]    dx_reg, dx_next;
    logic [DIM_W-1:0]    chan_reg, chan_next;
    logic [OFFSET_W-1:0] offset_reg, offset_next;

    logic dx_last;
    logic dy_last;
    logic pos_last;
    logic chan_last;
    logic query_acc;

    // Window walk end conditions
    assign dx_last   = ({1'b0, dx_reg} == cfg.roi - ROI_W'(1));
    assign dy_last   = ({1'b0, dy_reg} == cfg.roi - ROI_W'(1));
    assign pos_last  = dx_last && dy_last;
    assign chan_last = !status.pos_inside || (chan_reg == cfg.chans - DIM_W'(1));
    assign query_acc = (state_reg == ST_IDLE) && in_valid && (in_func == FUNC_QUERY);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (query_acc)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (status.advance && chan_last && pos_last)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // Advance the window and channel counters
    always_comb
    begin
        dy_next     = dy_reg;
        dx_next     = dx_reg;
        chan_next   = chan_reg;
        offset_next = offset_reg;
        if (query_acc)
        begin
            dy_next     = '0;
            dx_next     = '0;
            chan_next   = '0;
            offset_next = '0;
        end
        else if ((state_reg == ST_RUN) && status.advance)
        begin
            if (chan_last)
            begin
                chan_next   = '0;
                offset_next = offset_reg + OFFSET_W'(1);
                if (dx_last)
                begin
                    dx_next = '0;
                    dy_next = dy_reg + WIN_W'(1);
                end
                else
                begin
                    dx_next = dx_reg + WIN_W'(1);
                end
            end
            else
            begin
                chan_next = chan_reg + DIM_W'(1);
            end
        end
    end

    // Drive handshake and datapath commands
    always_comb
    begin
        in_ready      = (state_reg == ST_IDLE);
        cmd.load_wr   = (state_reg == ST_IDLE) && in_valid && (in_func == FUNC_LOAD);
        cmd.query_cap = query_acc;
        cmd.issue     = (state_reg == ST_RUN);
        cmd.first     = (chan_reg == '0);
        cmd.last_chan = chan_last;
        cmd.last_pos  = pos_last;
        cmd.dy        = dy_reg;
        cmd.dx        = dx_reg;
        cmd.chan      = chan_reg;
        cmd.offset    = offset_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            dy_reg     <= '0;
            dx_reg     <= '0;
            chan_reg   <= '0;
            offset_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            dy_reg     <= dy_next;
            dx_reg     <= dx_next;
            chan_reg   <= chan_next;
            offset_reg <= offset_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/lwc_datapath.sv
`default_nettype none

module lwc_datapath
    import lwc_pkg::*;
#(
    parameter int MAX_HEIGHT   = 32,
    parameter int MAX_WIDTH    = 32,
    parameter int MAX_CHANNELS = 32
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire lwc_cfg_t                   cfg,
    input  wire lwc_cmd_t                   cmd,
    input  wire logic                       in_map_select,
    input  wire logic [COORD_W-1:0]         in_chan,
    input  wire logic [COORD_W-1:0]         in_row,
    input  wire logic [COORD_W-1:0]         in_col,
    input  wire logic signed [FEAT_W-1:0]   in_feature_value,
    input  wire logic                       out_ready,
    output logic                            out_valid,
    output logic signed [SCORE_W-1:0]       out_score,
    output logic [OFFSET_W-1:0]             out_offset_index,
    output logic                            out_last,
    output lwc_status_t                     status
);

    localparam int DEPTH      = MAX_HEIGHT * MAX_WIDTH * MAX_CHANNELS;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ROW_STRIDE = MAX_WIDTH * MAX_CHANNELS;
    localparam int ACC_W      = (PROD_W + 1 + $clog2(MAX_CHANNELS) > SCORE_W + 1) ?
                                (PROD_W + 1 + $clog2(MAX_CHANNELS)) : (SCORE_W + 1);
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(SCORE_MAX);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(SCORE_MIN);

    // Feature stores
    logic [FEAT_W-1:0] image_mem  [DEPTH];
    logic [FEAT_W-1:0] kernel_mem [DEPTH];

    // Query pixel
    logic [COORD_W-1:0] qrow_reg;
    logic [COORD_W-1:0] qcol_reg;

    // Read stage
    logic                     s1_valid_reg;
    logic                     s1_first_reg;
    logic                     s1_last_chan_reg;
    logic                     s1_last_pos_reg;
    logic                     s1_zero_reg;
    logic [OFFSET_W-1:0]      s1_offset_reg;
    logic signed [FEAT_W-1:0] image_rdata_reg;
    logic signed [FEAT_W-1:0] kernel_rdata_reg;

    // Multiply stage
    logic                     s2_valid_reg;
    logic                     s2_first_reg;
    logic                     s2_last_chan_reg;
    logic                     s2_last_pos_reg;
    logic                     s2_zero_reg;
    logic [OFFSET_W-1:0]      s2_offset_reg;
    logic signed [PROD_W-1:0] product_reg;

    // Accumulate and output
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_sum;
    logic signed [SCORE_W-1:0] sat_score;
    logic                      out_valid_reg, out_valid_next;
    logic signed [SCORE_W-1:0] score_reg;
    logic [OFFSET_W-1:0]       offset_reg;
    logic                      last_reg;

    logic                      advance;
    logic signed [7:0]         iy;
    logic signed [7:0]         ix;
    logic                      query_inside;
    logic                      pos_inside;
    logic                      rd_en;
    logic                      load_in_range;
    logic [ADDR_W-1:0]         wr_addr;
    logic [ADDR_W-1:0]         image_rd_addr;
    logic [ADDR_W-1:0]         kernel_rd_addr;

    assign advance = !out_valid_reg || out_ready;

    // Window position and bounds
    assign iy = $signed({3'b000, qrow_reg}) - $signed({5'b00000, cfg.roi[3:1]})
              + $signed({5'b00000, cmd.dy});
    assign ix = $signed({3'b000, qcol_reg}) - $signed({5'b00000, cfg.roi[3:1]})
              + $signed({5'b00000, cmd.dx});
    assign query_inside = (DIM_W'(qrow_reg) < cfg.height) && (DIM_W'(qcol_reg) < cfg.width);
    assign pos_inside   = query_inside
                       && !iy[7] && (iy < $signed({2'b00, cfg.height}))
                       && !ix[7] && (ix < $signed({2'b00, cfg.width}));

    assign status.advance    = advance;
    assign status.pos_inside = pos_inside;

    // Store addresses
    assign load_in_range = (int'(in_row) < MAX_HEIGHT) && (int'(in_col) < MAX_WIDTH)
                        && (int'(in_chan) < MAX_CHANNELS);
    assign wr_addr = ADDR_W'(in_row) * ADDR_W'(ROW_STRIDE)
                   + ADDR_W'(in_col) * ADDR_W'(MAX_CHANNELS) + ADDR_W'(in_chan);
    assign image_rd_addr = ADDR_W'(iy[6:0]) * ADDR_W'(ROW_STRIDE)
                         + ADDR_W'(ix[6:0]) * ADDR_W'(MAX_CHANNELS) + ADDR_W'(cmd.chan);
    assign kernel_rd_addr = ADDR_W'(qrow_reg) * ADDR_W'(ROW_STRIDE)
                          + ADDR_W'(qcol_reg) * ADDR_W'(MAX_CHANNELS) + ADDR_W'(cmd.chan);
    assign rd_en = advance && cmd.issue && pos_inside;

    // Image store
    always_ff @(posedge clk)
    begin
        if (cmd.load_wr && load_in_range && (in_map_select == MAP_IMAGE))
        begin
            image_mem[wr_addr] <= in_feature_value;
        end
        if (rd_en)
        begin
            image_rdata_reg <= image_mem[image_rd_addr];
        end
    end

    // Kernel store
    always_ff @(posedge clk)
    begin
        if (cmd.load_wr && load_in_range && (in_map_select == MAP_KERNEL))
        begin
            kernel_mem[wr_addr] <= in_feature_value;
        end
        if (rd_en)
        begin
            kernel_rdata_reg <= kernel_mem[kernel_rd_addr];
        end
    end

    // Capture the queried pixel
    always_ff @(posedge clk)
    begin
        if (cmd.query_cap)
        begin
            qrow_reg <= in_row;
            qcol_reg <= in_col;
        end
    end

    // Stage tags and product
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= cmd.issue;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_first_reg     <= cmd.first;
            s1_last_chan_reg <= cmd.last_chan;
            s1_last_pos_reg  <= cmd.last_pos;
            s1_zero_reg      <= !pos_inside;
            s1_offset_reg    <= cmd.offset;
            s2_first_reg     <= s1_first_reg;
            s2_last_chan_reg <= s1_last_chan_reg;
            s2_last_pos_reg  <= s1_last_pos_reg;
            s2_zero_reg      <= s1_zero_reg;
            s2_offset_reg    <= s1_offset_reg;
            product_reg      <= image_rdata_reg * kernel_rdata_reg;
        end
    end

    // Accumulate and saturate
    always_comb
    begin
        if (s2_first_reg)
        begin
            acc_sum = ACC_W'(product_reg);
        end
        else
        begin
            acc_sum = acc_reg + ACC_W'(product_reg);
        end
        priority if (s2_zero_reg)
        begin
            sat_score = '0;
        end
        else if (acc_sum > SAT_HI)
        begin
            sat_score = SCORE_W'(SAT_HI);
        end
        else if (acc_sum < SAT_LO)
        begin
            sat_score = SCORE_W'(SAT_LO);
        end
        else
        begin
            sat_score = SCORE_W'(acc_sum);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s2_valid_reg)
        begin
            acc_reg <= acc_sum;
            if (s2_last_chan_reg)
            begin
                score_reg  <= sat_score;
                offset_reg <= s2_offset_reg;
                last_reg   <= s2_last_pos_reg;
            end
        end
    end

    // Hold the result word until taken
    always_comb
    begin
        if (advance && s2_valid_reg && s2_last_chan_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_score        = score_reg;
    assign out_offset_index = offset_reg;
    assign out_last         = last_reg;

endmodule

`default_nettype wire

>>> rtl/local_window_correlation_core.sv
// Local window correlation core.
// Input stream (s_axis_*): one word per load or query. A load word writes one
// signed Q8.8 feature element into the image or kernel store; loads may follow
// each other in every cycle while no query is running. A query word names a
// kernel pixel and yields roi*roi result words on m_axis_*, one per window
// position in row-major order, tlast on the final one.
// Walk: a query steps through the channels in use at each window position
// inside the map, and takes a single step at a position outside it, set by
// the single shared multiply-accumulate and the one read port of each store.
// Each score passes from the store read registers through the product register
// into the score register. A new word is taken as soon as the last position is issued.
// Stall: a full output register with m_axis_tready low freezes the whole
// pipeline, store reads included; nothing is dropped.
// Reset: registers return to roi 3 and a 32x32x32 map, the pipeline empties.
// Store contents are not cleared and must be loaded before they are queried.
// User must write configuration (APB) only while no query is in flight; unenforced.
`default_nettype none

module local_window_correlation_core
    import lwc_pkg::*;
#(
    parameter int MAX_HEIGHT   = 32,
    parameter int MAX_WIDTH    = 32,
    parameter int MAX_CHANNELS = 32,
    parameter int MAX_ROI      = 8
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // Input words
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // chan[4:0], row[9:5], col[14:10], feature_value[30:15]
    input  wire logic [1:0]  s_axis_tuser,  // func[0], map_select[1]
    // Result words
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,  // score[36:0], offset_index[42:37]
    output logic             m_axis_tlast
);

    logic [ROI_W-1:0] roi_size_reg;
    logic [DIM_W-1:0] map_height_reg;
    logic [DIM_W-1:0] map_width_reg;
    logic [DIM_W-1:0] channel_count_reg;

    logic [DIM_W-1:0] roi_clamped;
    lwc_cfg_t         cfg;
    lwc_cmd_t         cmd;
    lwc_status_t      status;
    logic             cfg_wr;

    logic signed [SCORE_W-1:0] out_score;
    logic [OFFSET_W-1:0]       out_offset_index;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            roi_size_reg      <= ROI_SIZE_RST;
            map_height_reg    <= MAP_HEIGHT_RST;
            map_width_reg     <= MAP_WIDTH_RST;
            channel_count_reg <= CHANNEL_COUNT_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_ROI_SIZE:      roi_size_reg      <= pwdata[ROI_W-1:0];
                REG_MAP_HEIGHT:    map_height_reg    <= pwdata[DIM_W-1:0];
                REG_MAP_WIDTH:     map_width_reg     <= pwdata[DIM_W-1:0];
                REG_CHANNEL_COUNT: channel_count_reg <= pwdata[DIM_W-1:0];
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        unique case (paddr[3:2])
            REG_ROI_SIZE:      prdata = 32'(roi_size_reg);
            REG_MAP_HEIGHT:    prdata = 32'(map_height_reg);
            REG_MAP_WIDTH:     prdata = 32'(map_width_reg);
            REG_CHANNEL_COUNT: prdata = 32'(channel_count_reg);
        endcase
    end

    // Clamp registers into their legal ranges
    assign roi_clamped = clamp_cfg({2'b00, roi_size_reg}, MAX_ROI);
    assign cfg.roi     = roi_clamped[ROI_W-1:0];
    assign cfg.height  = clamp_cfg(map_height_reg, MAX_HEIGHT);
    assign cfg.width   = clamp_cfg(map_width_reg, MAX_WIDTH);
    assign cfg.chans   = clamp_cfg(channel_count_reg, MAX_CHANNELS);

    lwc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (s_axis_tvalid),
        .in_func  (s_axis_tuser[0]),
        .status   (status),
        .in_ready (s_axis_tready),
        .cmd      (cmd)
    );

    lwc_datapath #(
        .MAX_HEIGHT   (MAX_HEIGHT),
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg),
        .cmd              (cmd),
        .in_map_select    (s_axis_tuser[1]),
        .in_chan          (s_axis_tdata[4:0]),
        .in_row           (s_axis_tdata[9:5]),
        .in_col           (s_axis_tdata[14:10]),
        .in_feature_value (s_axis_tdata[30:15]),
        .out_ready        (m_axis_tready),
        .out_valid        (m_axis_tvalid),
        .out_score        (out_score),
        .out_offset_index (out_offset_index),
        .out_last         (m_axis_tlast),
        .status           (status)
    );

    // Pack the result word
    assign m_axis_tdata = {5'b00000, out_offset_index, out_score};

    // A query word blocks the input on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == FUNC_QUERY))
        |=> !s_axis_tready)
        else $error("input still ready after a query word");

    // A load word never blocks the input
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == FUNC_LOAD))
        |=> s_axis_tready)
        else $error("load word left the block busy");

    // Output stall freezes the window walk
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.issue && !status.advance)
        |=> (cmd.issue && $stable(cmd.chan) && $stable(cmd.offset)))
        else $error("window walk moved during an output stall");

endmodule

`default_nettype wire
